### sv/rtcsf_pkg.sv
`timescale 1ns / 1ps
// rtcsf_pkg: shared types, constants and helper functions for the RTC set-frame block.
// No dependencies; used by the controller, datapath, top level and testbench.

package rtcsf_pkg;

	// frame layout
	localparam int FRAME_BYTES_DEF = 16;
	localparam int HDR_BYTES       = 9;     // command byte plus eight time bytes

	localparam logic [7:0] CMD_SET_TIME = 8'h01;
	localparam logic [7:0] FREEZE_BIT   = 8'h80;
	localparam logic [7:0] CTRL_B_RESET = 8'd10;

	// clock chip register offsets
	localparam logic [6:0] ADDR_SECONDS = 7'd0;
	localparam logic [6:0] ADDR_MINUTES = 7'd2;
	localparam logic [6:0] ADDR_HOURS   = 7'd4;
	localparam logic [6:0] ADDR_DOW     = 7'd6;
	localparam logic [6:0] ADDR_DATE    = 7'd7;
	localparam logic [6:0] ADDR_MONTH   = 7'd8;
	localparam logic [6:0] ADDR_YEAR    = 7'd9;
	localparam logic [6:0] ADDR_CTRL_B  = 7'h0B;
	localparam logic [6:0] ADDR_CENTURY = 7'h32;

	// write slots of a burst; slots 1..8 (except day of week) take frame byte of same index
	typedef logic [3:0] slot_t;
	localparam slot_t SLOT_FREEZE  = 4'd0;
	localparam slot_t SLOT_SECONDS = 4'd1;
	localparam slot_t SLOT_MINUTES = 4'd2;
	localparam slot_t SLOT_HOURS   = 4'd3;
	localparam slot_t SLOT_DOW     = 4'd4;
	localparam slot_t SLOT_DATE    = 4'd5;
	localparam slot_t SLOT_MONTH   = 4'd6;
	localparam slot_t SLOT_YEAR    = 4'd7;
	localparam slot_t SLOT_CENTURY = 4'd8;
	localparam slot_t SLOT_RESTORE = 4'd9;

	// offset that keeps the day-of-week sum non-negative; a multiple of 7
	localparam logic [11:0] DOW_BIAS_M1 = 12'd447;  // 448 - 1

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_MOD,
		ST_REM,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic capture;    // take rx byte
		logic dow_sum;    // day of week: partial sum and 26*(m+1)
		logic dow_div;    // add (26*(m+1))/10
		logic dow_mod;    // quotient by 7
		logic dow_rem;    // remainder plus one
		logic emit_load;  // load next write into output register
	} dp_cmd_t;

	typedef struct packed {
		logic frame_last; // current byte closes the frame
		logic cmd_set;    // byte 0 is the set-time command
		logic out_free;   // output register can take a write
		logic emit_last;  // slot counter on the restore write
	} dp_stat_t;

	// binary to BCD, tens nibble shifted and added, truncated to 8 bits
	function automatic logic [7:0] to_bcd(input logic [7:0] v);
		logic [15:0] prod;
		logic [4:0]  tens;
		logic [7:0]  ones;
		prod = {8'b0, v} * 16'd205;
		tens = prod[15:11];
		ones = v - 8'({3'b0, tens} * 8'd10);
		return {tens[3:0], 4'b0000} + ones;
	endfunction

endpackage

### sv/rtcsf_ifs.sv
`timescale 1ns / 1ps
// rtcsf_ifs: valid/ready channel interfaces for received bytes, register writes and config.
// Standalone; no package dependency.

interface rtcsf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rtcsf_wr_if;
	logic       valid;
	logic       ready;
	logic [6:0] reg_addr;
	logic [7:0] reg_data;
	logic       last_write;
	modport source (output valid, output reg_addr, output reg_data, output last_write,
		input ready);
	modport sink (input valid, input reg_addr, input reg_data, input last_write,
		output ready);
endinterface

interface rtcsf_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] control_b_value;
	modport source (output valid, output control_b_value, input ready);
	modport sink (input valid, input control_b_value, output ready);
endinterface

### sv/rtcsf_ctrl.sv
`timescale 1ns / 1ps
// rtcsf_ctrl: sequencer for frame capture, day-of-week steps and the write burst.
// Depends on rtcsf_pkg.

module rtcsf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_ready,
	input  rtcsf_pkg::dp_stat_t stat,
	output rtcsf_pkg::dp_cmd_t  cmd
);

	rtcsf_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtcsf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rtcsf_pkg::ST_IDLE: begin
				if (rx_valid && stat.frame_last && stat.cmd_set) begin
					state_d = rtcsf_pkg::ST_SUM;
				end
			end
			rtcsf_pkg::ST_SUM:  state_d = rtcsf_pkg::ST_DIV;
			rtcsf_pkg::ST_DIV:  state_d = rtcsf_pkg::ST_MOD;
			rtcsf_pkg::ST_MOD:  state_d = rtcsf_pkg::ST_REM;
			rtcsf_pkg::ST_REM:  state_d = rtcsf_pkg::ST_EMIT;
			rtcsf_pkg::ST_EMIT: begin
				if (stat.out_free && stat.emit_last) begin
					state_d = rtcsf_pkg::ST_IDLE;
				end
			end
			default: state_d = rtcsf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rx_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			rtcsf_pkg::ST_IDLE: begin
				rx_ready    = 1'b1;
				cmd.capture = rx_valid;
			end
			rtcsf_pkg::ST_SUM:  cmd.dow_sum = 1'b1;
			rtcsf_pkg::ST_DIV:  cmd.dow_div = 1'b1;
			rtcsf_pkg::ST_MOD:  cmd.dow_mod = 1'b1;
			rtcsf_pkg::ST_REM:  cmd.dow_rem = 1'b1;
			rtcsf_pkg::ST_EMIT: cmd.emit_load = stat.out_free;
			default: begin
				rx_ready = 1'b0;
				cmd      = '0;
			end
		endcase
	end

endmodule

### sv/rtcsf_dp.sv
`timescale 1ns / 1ps
// rtcsf_dp: frame byte registers, byte counter, day-of-week arithmetic, BCD and output register.
// Depends on rtcsf_pkg; driven by rtcsf_ctrl.

module rtcsf_dp #(
	parameter int FRAME_BYTES = rtcsf_pkg::FRAME_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rtcsf_pkg::dp_cmd_t  cmd,
	output rtcsf_pkg::dp_stat_t stat,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_fire,
	input  logic [7:0]         cfg_data,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [6:0]         out_addr,
	output logic [7:0]         out_data,
	output logic               out_last
);

	localparam int CW = $clog2(FRAME_BYTES);
	localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_BYTES - 1);

	logic [CW-1:0]     count_q;
	logic [7:0]        frame_q [rtcsf_pkg::HDR_BYTES];
	logic [7:0]        ctrl_b_q;
	rtcsf_pkg::slot_t  slot_q;

	// day-of-week working registers
	logic [10:0] asum_q;
	logic [12:0] p26_q;
	logic [10:0] u_q;
	logic [8:0]  q7_q;
	logic [2:0]  dow_q;

	logic        out_valid_q;
	logic [6:0]  out_addr_q;
	logic [7:0]  out_data_q;
	logic        out_last_q;

	logic        out_free;
	logic        load;

	logic [7:0]  yr, cen, mon, dat;
	logic [11:0] asum_full;
	logic [8:0]  m_inc;
	logic [26:0] div_prod;
	logic [24:0] mod_prod;
	logic [10:0] rem_full;
	logic [7:0]  bcd_src;
	logic [6:0]  addr_d;
	logic [7:0]  data_d;

	assign out_free = !out_valid_q || out_ready;
	assign load     = cmd.emit_load && out_free;

	assign stat.frame_last = (count_q == LAST_IDX);
	assign stat.cmd_set    = (frame_q[0] == rtcsf_pkg::CMD_SET_TIME);
	assign stat.out_free   = out_free;
	assign stat.emit_last  = (slot_q == rtcsf_pkg::SLOT_RESTORE);

	assign yr  = frame_q[7];
	assign cen = frame_q[8];
	assign mon = frame_q[6];
	assign dat = frame_q[5];

	// biased sum, never negative, fits 11 bits
	assign asum_full = rtcsf_pkg::DOW_BIAS_M1 + {4'b0, yr} + {6'b0, yr[7:2]}
		+ {6'b0, cen[7:2]} + {4'b0, dat} - {3'b0, cen, 1'b0};
	assign m_inc     = {1'b0, mon} + 9'd1;
	assign div_prod  = {14'b0, p26_q} * 27'd6554;   // /10 by reciprocal
	assign mod_prod  = {14'b0, u_q} * 25'd9363;     // /7 by reciprocal
	assign rem_full  = u_q - 11'({q7_q, 3'b000} - {3'b000, q7_q});

	// counter and frame capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.capture) begin
			count_q <= (count_q == LAST_IDX) ? '0 : count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < rtcsf_pkg::HDR_BYTES; i++) begin
			if (cmd.capture && count_q == CW'(i)) begin
				frame_q[i] <= rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_b_q <= rtcsf_pkg::CTRL_B_RESET;
		end else if (cfg_fire) begin
			ctrl_b_q <= cfg_data;
		end
	end

	// day-of-week steps
	always_ff @(posedge clk) begin
		if (cmd.dow_sum) begin
			asum_q <= asum_full[10:0];
			p26_q  <= 13'({4'b0, m_inc} * 13'd26);
		end
		if (cmd.dow_div) begin
			u_q <= asum_q + {1'b0, div_prod[25:16]};
		end
		if (cmd.dow_mod) begin
			q7_q <= mod_prod[24:16];
		end
		if (cmd.dow_rem) begin
			dow_q <= rem_full[2:0] + 3'd1;
		end
	end

	// write slot decode
	always_comb begin
		bcd_src = frame_q[1];
		case (slot_q)
			rtcsf_pkg::SLOT_MINUTES: bcd_src = frame_q[2];
			rtcsf_pkg::SLOT_HOURS:   bcd_src = frame_q[3];
			rtcsf_pkg::SLOT_DATE:    bcd_src = frame_q[5];
			rtcsf_pkg::SLOT_MONTH:   bcd_src = frame_q[6];
			rtcsf_pkg::SLOT_YEAR:    bcd_src = frame_q[7];
			rtcsf_pkg::SLOT_CENTURY: bcd_src = frame_q[8];
			default:                 bcd_src = frame_q[1];
		endcase
	end

	always_comb begin
		addr_d = rtcsf_pkg::ADDR_CTRL_B;
		data_d = rtcsf_pkg::to_bcd(bcd_src);
		unique case (slot_q)
			rtcsf_pkg::SLOT_FREEZE: begin
				addr_d = rtcsf_pkg::ADDR_CTRL_B;
				data_d = ctrl_b_q | rtcsf_pkg::FREEZE_BIT;
			end
			rtcsf_pkg::SLOT_SECONDS: addr_d = rtcsf_pkg::ADDR_SECONDS;
			rtcsf_pkg::SLOT_MINUTES: addr_d = rtcsf_pkg::ADDR_MINUTES;
			rtcsf_pkg::SLOT_HOURS:   addr_d = rtcsf_pkg::ADDR_HOURS;
			rtcsf_pkg::SLOT_DOW: begin
				addr_d = rtcsf_pkg::ADDR_DOW;
				data_d = {5'b0, dow_q};
			end
			rtcsf_pkg::SLOT_DATE:    addr_d = rtcsf_pkg::ADDR_DATE;
			rtcsf_pkg::SLOT_MONTH:   addr_d = rtcsf_pkg::ADDR_MONTH;
			rtcsf_pkg::SLOT_YEAR:    addr_d = rtcsf_pkg::ADDR_YEAR;
			rtcsf_pkg::SLOT_CENTURY: addr_d = rtcsf_pkg::ADDR_CENTURY;
			rtcsf_pkg::SLOT_RESTORE: begin
				addr_d = rtcsf_pkg::ADDR_CTRL_B;
				data_d = ctrl_b_q;
			end
			default: begin
				addr_d = rtcsf_pkg::ADDR_CTRL_B;
				data_d = ctrl_b_q;
			end
		endcase
	end

	// slot counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= rtcsf_pkg::SLOT_FREEZE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				slot_q      <= (slot_q == rtcsf_pkg::SLOT_RESTORE) ? rtcsf_pkg::SLOT_FREEZE
					: slot_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_addr_q <= addr_d;
			out_data_q <= data_d;
			out_last_q <= (slot_q == rtcsf_pkg::SLOT_RESTORE);
		end
	end

	assign out_valid = out_valid_q;
	assign out_addr  = out_addr_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	// no byte is taken in the middle of a burst
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> slot_q == rtcsf_pkg::SLOT_FREEZE)
		else $error("byte captured during a write burst");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LAST_IDX)
		else $error("byte counter past end of frame");

	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		load && slot_q == rtcsf_pkg::SLOT_RESTORE |=> out_valid_q && out_last_q)
		else $error("restore write not tagged as last");

	a_dow_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dow_rem |=> dow_q != 3'd0)
		else $error("day of week outside 1 to 7");

endmodule

### sv/rtc_set_frame_to_register_writes_core.sv
`timescale 1ns / 1ps
// rtc_set_frame_to_register_writes_core: top level of the RTC set-time frame decoder.
// Depends on rtcsf_pkg, rtcsf_ifs, rtcsf_ctrl and rtcsf_dp.
//
// Usage:
//   rx  : one received serial byte per transaction. FRAME_BYTES bytes form a frame;
//         byte 0 is the command, bytes 1..8 are seconds, minutes, hours, (unused),
//         date, month, year and century, all binary.
//   wr  : clock-chip register writes (reg_addr, reg_data, last_write).
//   cfg : writes the control B shadow value (reset 10), always ready. Write it only
//         while the block is idle.
//   A frame with command 1 yields ten writes: control B with the freeze bit, the BCD
//   time fields with the day of week in the middle, then control B restored with
//   last_write set. Any other command drops the frame; the byte counter restarts.
// Timing:
//   Bytes are taken one per cycle while idle. After the closing byte of a set-time frame,
//   the day-of-week arithmetic runs in steps (sum, divide by 10, divide by 7, remainder),
//   then one write is loaded per cycle into the output register while it is free.
//   rx is held off during the compute and burst.
// Reset: arst_n clears the byte counter, sequencer, slot counter and output valid.
// Stall: while wr.ready is low the pending write holds in the output register and the
// burst pauses; once the last write is loaded, rx is taken again even if it waits.

module rtc_set_frame_to_register_writes_core #(
	parameter int FRAME_BYTES = rtcsf_pkg::FRAME_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rtcsf_rx_if.sink  rx,
	rtcsf_wr_if.source wr,
	rtcsf_cfg_if.sink cfg
);

	rtcsf_pkg::dp_cmd_t  cmd;
	rtcsf_pkg::dp_stat_t stat;
	logic                rx_ready;

	// config register is a plain write; no back-pressure
	assign cfg.ready = 1'b1;
	assign rx.ready  = rx_ready;

	rtcsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rtcsf_dp #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.rx_byte   (rx.rx_byte),
		.cfg_fire  (cfg.valid),
		.cfg_data  (cfg.control_b_value),
		.out_ready (wr.ready),
		.out_valid (wr.valid),
		.out_addr  (wr.reg_addr),
		.out_data  (wr.reg_data),
		.out_last  (wr.last_write)
	);

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for rtc_set_frame_to_register_writes_core.
// Depends on rtcsf_pkg, rtcsf_ifs and the core. A built-in decoder predicts the register-write bursts,
// and the bench checks every write under random idling and back-pressure.

module tb_top;

	localparam int FRAME_LEN   = rtcsf_pkg::FRAME_BYTES_DEF;
	localparam int SETTLE      = 40;    // idle cycles before a control B write or the end
	localparam int HOLD_CYCLES = 80;    // long receiver hold-off, fills the block
	localparam int IDLE_PCT    = 35;

	typedef struct packed {
		logic [6:0] addr;
		logic [7:0] data;
		logic       is_last;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n;

	rtcsf_rx_if  rx_ch ();
	rtcsf_wr_if  wr_ch ();
	rtcsf_cfg_if cfg_ch ();

	rtc_set_frame_to_register_writes_core #(
		.FRAME_BYTES(FRAME_LEN)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.wr     (wr_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// --------------------------------------------------------------------
	// Decoder shadow: own copy of the frame buffer, fill count and control B.
	// --------------------------------------------------------------------
	logic [7:0]  frame_buf [FRAME_LEN];
	int unsigned frame_fill;
	logic [7:0]  ctrl_b_shadow;
	reg_write_t  due_writes[$];     // writes still owed by the block, oldest first
	logic [7:0]  tx_bytes[$];       // bytes waiting for the rx driver

	int unsigned errors;
	int unsigned bytes_taken;
	int unsigned bursts_due;
	int unsigned frames_dropped;
	int unsigned writes_seen;       // updated with NBA, read by the ready process
	int unsigned hold_left;

	// binary to BCD; the tens digit may exceed 9, the sum wraps at 8 bits
	function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
		int unsigned r;
		r = (int'(v) / 10) * 16 + int'(v) % 10;
		return r[7:0];
	endfunction

	// day of week from date, month, year, century; floored mod keeps it 1..7
	function automatic logic [7:0] weekday_of(input logic [7:0] d, input logic [7:0] m,
		input logic [7:0] y, input logic [7:0] c);
		int x;
		int r;
		x = int'(y) + (int'(y) >> 2) + (int'(c) >> 2) - 2 * int'(c)
			+ (26 * (int'(m) + 1)) / 10 + int'(d) - 1;
		r = x % 7;
		if (r < 0) begin
			r = r + 7;
		end
		return 8'(r + 1);
	endfunction

	function automatic reg_write_t mk_write(input logic [6:0] a, input logic [7:0] d,
		input logic l);
		reg_write_t w;
		w.addr    = a;
		w.data    = d;
		w.is_last = l;
		return w;
	endfunction

	// One accepted rx byte. Closing byte of a set-time frame queues the ten-write burst;
	// frame bytes 1..8 are sec, min, hour, (unused), date, month, year, century.
	task automatic decode_rx_byte(input logic [7:0] b);
		frame_buf[frame_fill] = b;
		frame_fill++;
		if (frame_fill == FRAME_LEN) begin
			frame_fill = 0;
			if (frame_buf[0] == rtcsf_pkg::CMD_SET_TIME) begin
				bursts_due++;
				due_writes.push_back(mk_write(rtcsf_pkg::ADDR_CTRL_B,
					ctrl_b_shadow | rtcsf_pkg::FREEZE_BIT, 1'b0));
				due_writes.push_back(mk_write(rtcsf_pkg::ADDR_SECONDS,
					bin_to_bcd(frame_buf[1]), 1'b0));
				due_writes.push_back(mk_write(rtcsf_pkg::ADDR_MINUTES,
					bin_to_bcd(frame_buf[2]), 1'b0));
				due_writes.push_back(mk_write(rtcsf_pkg::ADDR_HOURS,
					bin_to_bcd(frame_buf[3]), 1'b0));
				due_writes.push_back(mk_write(rtcsf_pkg::ADDR_DOW,
					weekday_of(frame_buf[5], frame_buf[6], frame_buf[7], frame_buf[8]),
					1'b0));
				due_writes.push_back(mk_write(rtcsf_pkg::ADDR_DATE,
					bin_to_bcd(frame_buf[5]), 1'b0));
				due_writes.push_back(mk_write(rtcsf_pkg::ADDR_MONTH,
					bin_to_bcd(frame_buf[6]), 1'b0));
				due_writes.push_back(mk_write(rtcsf_pkg::ADDR_YEAR,
					bin_to_bcd(frame_buf[7]), 1'b0));
				due_writes.push_back(mk_write(rtcsf_pkg::ADDR_CENTURY,
					bin_to_bcd(frame_buf[8]), 1'b0));
				due_writes.push_back(mk_write(rtcsf_pkg::ADDR_CTRL_B, ctrl_b_shadow, 1'b1));
			end else begin
				frames_dropped++;
			end
		end
	endtask

	// --------------------------------------------------------------------
	// Monitor: samples pre-edge values of every channel at the rising edge.
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		reg_write_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				ctrl_b_shadow = cfg_ch.control_b_value;
			end
			if (rx_ch.valid && rx_ch.ready) begin
				decode_rx_byte(rx_ch.rx_byte);
				bytes_taken++;
			end
			if (wr_ch.valid && wr_ch.ready) begin
				writes_seen <= writes_seen + 1;
				if (due_writes.size() == 0) begin
					$error("unexpected write transaction: reg_addr %0d reg_data 0x%02h",
						wr_ch.reg_addr, wr_ch.reg_data);
					errors++;
				end else begin
					want = due_writes.pop_front();
					if (wr_ch.reg_addr !== want.addr) begin
						$error("reg_addr: expected %0d, actual %0d", want.addr, wr_ch.reg_addr);
						errors++;
					end
					if (wr_ch.reg_data !== want.data) begin
						$error("reg_data: expected 0x%02h, actual 0x%02h", want.data,
							wr_ch.reg_data);
						errors++;
					end
					if (wr_ch.last_write !== want.is_last) begin
						$error("last_write: expected %0b, actual %0b", want.is_last,
							wr_ch.last_write);
						errors++;
					end
				end
			end
		end
	end

	// --------------------------------------------------------------------
	// rx driver: pops tx_bytes. Idles ~35% of cycles, except in a steady window
	// of bytes and during the long wr hold-off so the block backs up.
	// --------------------------------------------------------------------
	int unsigned bytes_offered;

	always @(posedge clk or negedge arst_n) begin
		logic steady;
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= 8'h00;
			bytes_offered = 0;
		end else if (!rx_ch.valid || rx_ch.ready) begin
			steady = (bytes_offered >= 200 && bytes_offered < 290) || hold_left != 0;
			if (tx_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				rx_ch.valid   <= 1'b1;
				rx_ch.rx_byte <= tx_bytes.pop_front();
				bytes_offered++;
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------------
	// wr ready: random stalls, a steady window, and one long hold-off counted here.
	// --------------------------------------------------------------------
	logic hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ch.ready <= 1'b0;
			hold_left   <= 0;
			hold_done   <= 1'b0;
		end else if (hold_left != 0) begin
			wr_ch.ready <= 1'b0;
			hold_left   <= hold_left - 1;
		end else if (!hold_done && writes_seen >= 25) begin
			wr_ch.ready <= 1'b0;
			hold_left   <= HOLD_CYCLES;
			hold_done   <= 1'b1;
		end else begin
			wr_ch.ready <= (writes_seen >= 100 && writes_seen < 160)
				|| ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// --------------------------------------------------------------------
	// Stimulus
	// --------------------------------------------------------------------
	task automatic push_frame(input logic [7:0] f [FRAME_LEN]);
		for (int i = 0; i < FRAME_LEN; i++) begin
			tx_bytes.push_back(f[i]);
		end
	endtask

	// random frame: mostly set-time with plausible or wild time bytes
	task automatic push_random_frame();
		logic [7:0] f [FRAME_LEN];
		logic       sane;
		for (int i = 0; i < FRAME_LEN; i++) begin
			f[i] = 8'($urandom_range(255));
		end
		if ($urandom_range(99) < 75) begin
			f[0] = rtcsf_pkg::CMD_SET_TIME;
		end else begin
			while (f[0] == rtcsf_pkg::CMD_SET_TIME) begin
				f[0] = 8'($urandom_range(255));
			end
		end
		sane = 1'($urandom_range(1));
		if (sane) begin
			f[1] = 8'($urandom_range(59));
			f[2] = 8'($urandom_range(59));
			f[3] = 8'($urandom_range(23));
			f[5] = 8'($urandom_range(31, 1));
			f[6] = 8'($urandom_range(12, 1));
			f[7] = 8'($urandom_range(99));
			f[8] = 8'($urandom_range(21, 19));
		end
		push_frame(f);
	endtask

	// let the block drain: all bytes taken, all writes seen, then a quiet gap
	task automatic wait_drained();
		while (tx_bytes.size() != 0 || rx_ch.valid || due_writes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_ctrl_b(input logic [7:0] v);
		cfg_ch.valid           <= 1'b1;
		cfg_ch.control_b_value <= v;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [7:0] f [FRAME_LEN];

		// known values on every input from time zero
		arst_n                 = 1'b0;
		rx_ch.valid            = 1'b0;
		rx_ch.rx_byte          = 8'h00;
		wr_ch.ready            = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.control_b_value = 8'h00;
		errors                 = 0;
		bytes_taken            = 0;
		bursts_due             = 0;
		frames_dropped         = 0;
		writes_seen            = 0;
		frame_fill             = 0;
		ctrl_b_shadow          = rtcsf_pkg::CTRL_B_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all-ones frame (BCD above 99, largest month term in the day-of-week sum)
		for (int i = 0; i < FRAME_LEN; i++) begin
			f[i] = 8'hFF;
		end
		f[0] = rtcsf_pkg::CMD_SET_TIME;
		push_frame(f);
		// directed: zeros with century 255, so the day-of-week sum goes negative
		for (int i = 0; i < FRAME_LEN; i++) begin
			f[i] = 8'h00;
		end
		f[0] = rtcsf_pkg::CMD_SET_TIME;
		f[8] = 8'hFF;
		push_frame(f);

		// phase 0: control B at its reset value
		repeat (5) push_random_frame();
		wait_drained();

		// phase 1: control B all ones
		set_ctrl_b(8'hFF);
		repeat (6) push_random_frame();
		wait_drained();

		// phase 2: control B zero
		set_ctrl_b(8'h00);
		repeat (6) push_random_frame();
		wait_drained();

		// phase 3: random control B; ends on a partial frame that must stay silent
		set_ctrl_b(8'($urandom_range(255)));
		repeat (7) push_random_frame();
		repeat (9) tx_bytes.push_back(8'($urandom_range(255)));
		wait_drained();

		$display("Run covered %0d rx bytes and %0d checked writes: %0d set-time bursts,",
			bytes_taken, writes_seen, bursts_due);
		$display("%0d dropped frames, four control B settings, one long write hold-off.",
			frames_dropped);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

### rtc_set_frame_to_register_writes_core.f
sv/rtcsf_pkg.sv
sv/rtcsf_ifs.sv
sv/rtcsf_ctrl.sv
sv/rtcsf_dp.sv
sv/rtc_set_frame_to_register_writes_core.sv
test/tb_top.sv
